@@ hdl/bta_pkg.sv @@
package bta_pkg;

	// Bitmap geometry
	localparam int WORD_SHIFT = 5;
	localparam int NUM_WORDS  = 2048;
	localparam int WBITS      = 1 << WORD_SHIFT;
	localparam int ADDR_W     = $clog2(NUM_WORDS);
	localparam int TAG_W      = 16;
	localparam int HI_W       = TAG_W - WORD_SHIFT;
	localparam logic [TAG_W-1:0] NO_TAG = '1;

	// Operation codes carried on the input tuser
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// Result status carried on the output tuser
	localparam logic STAT_OK        = 1'b0;
	localparam logic STAT_EXHAUSTED = 1'b1;

	typedef logic [WBITS-1:0]  word_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [TAG_W-1:0]  tag_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FREE
	} state_t;

	// Lowest clear bit of a word (only meaningful when the word is not all ones)
	function automatic logic [WORD_SHIFT-1:0] first_zero(input word_t w);
		logic [WORD_SHIFT-1:0] idx;
		idx = '0;
		for (int i = WBITS - 1; i >= 0; i--) begin
			if (!w[i]) idx = WORD_SHIFT'(i);
		end
		return idx;
	endfunction

endpackage

@@ hdl/bta_ram.sv @@
module bta_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word with registered data
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/bitmap_tag_allocator_unit.sv @@
// Free: one bitmap read, then a write-back of the cleared bit as the result is loaded.
// Allocate: one bitmap read, then one full bitmap word skipped per cycle; the scan
// starts at the lowest word that may still hold a clear bit.
// One request at a time; the bitmap RAM's one read port sets the pace.
// After reset a clearing pass writes all 2048 bitmap words with s_tready
// low, marking tag 0 and tag 65535 used.
module bitmap_tag_allocator_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [15:0]              s_tdata,  // [15:0] tag_in
	input  logic                     s_tuser,  // [0] func
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [15:0]              m_tdata,  // [15:0] tag_out
	output logic                     m_tuser   // [0] status
);

	bta_pkg::state_t state_q, state_nxt;
	bta_pkg::addr_t  ptr_q, hint_q, clr_q;
	bta_pkg::tag_t   req_tag_q;
	logic            m_tvalid_q;
	bta_pkg::tag_t   m_tdata_q;
	logic            m_tuser_q;

	bta_pkg::addr_t  rd_addr, wr_addr;
	bta_pkg::word_t  rd_data, wr_data;
	logic            wr_en;
	logic            accept, out_free;
	logic            res_load, res_status, ptr_adv, hint_set;
	bta_pkg::tag_t   res_tag;
	bta_pkg::addr_t  hint_val;

	logic                          word_full, ptr_last;
	logic [bta_pkg::WORD_SHIFT-1:0] zbit;
	logic [31:0]                   cand;
	logic                          cand_bad;
	logic [bta_pkg::HI_W-1:0]      req_hi, in_hi;
	logic                          req_in_range;
	logic [bta_pkg::WORD_SHIFT-1:0] req_bit;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Decode scan word and request tag
	assign word_full    = &rd_data;
	assign ptr_last     = (ptr_q == bta_pkg::ADDR_W'(bta_pkg::NUM_WORDS - 1));
	assign zbit         = bta_pkg::first_zero(rd_data);
	assign cand         = 32'({ptr_q, zbit});
	assign cand_bad     = (cand >= 32'(bta_pkg::NO_TAG));
	assign req_hi       = req_tag_q[bta_pkg::TAG_W-1:bta_pkg::WORD_SHIFT];
	assign in_hi        = s_tdata[bta_pkg::TAG_W-1:bta_pkg::WORD_SHIFT];
	assign req_in_range = (32'(req_hi) < 32'(bta_pkg::NUM_WORDS));
	assign req_bit      = req_tag_q[bta_pkg::WORD_SHIFT-1:0];

	bta_ram #(
		.WIDTH(bta_pkg::WBITS),
		.DEPTH(bta_pkg::NUM_WORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bta_pkg::ST_CLEAR: begin
				if (clr_q == bta_pkg::ADDR_W'(bta_pkg::NUM_WORDS - 1)) begin
					state_nxt = bta_pkg::ST_IDLE;
				end
			end
			bta_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = (s_tuser == bta_pkg::FUNC_FREE) ?
						bta_pkg::ST_FREE : bta_pkg::ST_SCAN;
				end
			end
			bta_pkg::ST_SCAN: begin
				if (res_load) state_nxt = bta_pkg::ST_IDLE;
			end
			bta_pkg::ST_FREE: begin
				if (out_free) state_nxt = bta_pkg::ST_IDLE;
			end
			default: state_nxt = bta_pkg::ST_IDLE;
		endcase
	end

	// Memory access, result and pointer control
	always_comb begin
		s_tready   = 1'b0;
		rd_addr    = ptr_q;
		wr_en      = 1'b0;
		wr_addr    = ptr_q;
		wr_data    = rd_data;
		res_load   = 1'b0;
		res_tag    = bta_pkg::NO_TAG;
		res_status = bta_pkg::STAT_OK;
		ptr_adv    = 1'b0;
		hint_set   = 1'b0;
		hint_val   = hint_q;
		unique case (state_q)
			bta_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == '0) wr_data[0] = 1'b1;
				if (clr_q == bta_pkg::ADDR_W'(bta_pkg::NUM_WORDS - 1)) begin
					wr_data[bta_pkg::WBITS-1] = 1'b1;
				end
			end
			bta_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				rd_addr  = (s_tuser == bta_pkg::FUNC_FREE) ? bta_pkg::ADDR_W'(in_hi) : hint_q;
			end
			bta_pkg::ST_SCAN: begin
				// Skip a full word, or finish on a clear bit or at the end
				if (word_full && !ptr_last) begin
					ptr_adv = 1'b1;
					rd_addr = ptr_q + 1'b1;
				end else if (out_free) begin
					res_load = 1'b1;
					if (word_full || cand_bad) begin
						res_tag    = bta_pkg::NO_TAG;
						res_status = bta_pkg::STAT_EXHAUSTED;
					end else begin
						res_tag       = bta_pkg::TAG_W'(cand);
						wr_en         = 1'b1;
						wr_data[zbit] = 1'b1;
						hint_set      = 1'b1;
						hint_val      = ptr_q;
					end
				end
			end
			bta_pkg::ST_FREE: begin
				rd_addr = bta_pkg::ADDR_W'(req_hi);
				wr_addr = bta_pkg::ADDR_W'(req_hi);
				if (out_free) begin
					res_load = 1'b1;
					res_tag  = req_tag_q;
					if (req_in_range) begin
						wr_en            = 1'b1;
						wr_data[req_bit] = 1'b0;
						if (bta_pkg::ADDR_W'(req_hi) < hint_q) begin
							hint_set = 1'b1;
							hint_val = bta_pkg::ADDR_W'(req_hi);
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bta_pkg::ST_CLEAR;
			clr_q      <= '0;
			hint_q     <= '0;
			ptr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == bta_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (hint_set) hint_q <= hint_val;
			if (accept) ptr_q <= hint_q;
			else if (ptr_adv) ptr_q <= ptr_q + 1'b1;
			if (res_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Hold request tag and result word
	always_ff @(posedge clk) begin
		if (accept) req_tag_q <= s_tdata;
		if (res_load) begin
			m_tdata_q <= res_tag;
			m_tuser_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
